// ===== design/assert_macros.svh =====
// assertion macros used by the top level of the sender window
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, quiet while reset is held
`define SRSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define SRSW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/srsw_pkg.sv =====
// shared constants, codes and controller/datapath signal groups
`default_nettype none
package srsw_pkg;

  localparam int WINDOW_MAX = 8;
  localparam int SEQ_BITS   = 16;
  localparam int TIME_BITS  = 16;

  localparam int FIELD_BITS   = 16;
  localparam int WS_BITS      = 4;
  localparam int TIMEOUT_BITS = 16;
  localparam int OP_BITS      = 2;

  localparam int SLOT_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int CMP_BITS  = ((SEQ_BITS > FIELD_BITS) ? SEQ_BITS : FIELD_BITS) + 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = (WS_BITS > TIMEOUT_BITS) ? WS_BITS : TIMEOUT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT     = 1'd1;

  localparam logic [WS_BITS-1:0]      WINDOW_SIZE_RESET = 4'd1;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET     = 16'd10;

  localparam logic [OP_BITS-1:0] OP_START = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic start;     // load a new buffer, clear the window
    logic ack;       // apply an acknowledgement
    logic tick;      // advance time, clear scan counters
    logic slide;     // shift window by one slot
    logic scan;      // examine one slot, maybe queue a send request
    logic complete;  // queue the buffer complete request
    logic flush;     // hand the queued request out as the last one
  } srsw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slide_more;
    logic scan_more;
    logic slot_due;
    logic complete_due;
    logic pend_valid;
    logic out_free;
  } srsw_sts_t;

endpackage
`default_nettype wire

// ===== design/selective_repeat_sender_window.sv =====
// top level of the selective-repeat sender window
//
// Sender side of a selective-repeat ARQ over one buffer of numbered frames.
// Each input request carries an operation in s_axis_tuser: start loads the
// frame count and final-buffer flag and clears the window; ack marks a slot
// inside the window acknowledged (or, when negative, forces it to resend);
// tick advances time, slides the window past the acknowledged prefix and
// emits one send request per frame that is unsent, forced or timed out,
// followed by a buffer complete request once every frame is acknowledged.
// Start and ack produce nothing. A tick runs these steps in order: it is
// accepted, slides one slot per step and then sees the slide end, scans one
// slot per step through a single shared elapsed-time compare and then sees
// the scan end, then queues the completion and hands over the last request;
// a stalled output stretches this. The window size register takes effect
// at once, 0 acts as 1 and values above eight act as eight.
`default_nettype none
`include "assert_macros.svh"
module selective_repeat_sender_window (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [srsw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srsw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [39:0]                         s_axis_tdata,  // frame_count, final_buffer,
                                                             // ack_seq, ack_negative,
                                                             // ack_corrupt, zero fill
  input  logic [1:0]                          s_axis_tuser,  // operation
  // result requests
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // seq_num, end_of_transmission,
                                                             // zero fill
  output logic                                m_axis_tuser,  // kind
  output logic                                m_axis_tlast
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;
  srsw_sts_t sts;

  logic [FIELD_BITS-1:0] out_seq;
  logic                  out_eot;

  // controller: decides which datapath step runs in each cycle
  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window state, scan unit, held request and output register
  srsw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_count  (s_axis_tdata[15:0]),
    .final_buffer (s_axis_tdata[16]),
    .ack_seq      (s_axis_tdata[32:17]),
    .ack_negative (s_axis_tdata[33]),
    .ack_corrupt  (s_axis_tdata[34]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_kind     (m_axis_tuser),
    .out_seq      (out_seq),
    .out_eot      (out_eot),
    .out_last     (m_axis_tlast)
  );

  // pack the result fields, lowest bits first
  assign m_axis_tdata = {7'd0, out_eot, out_seq};

  // at most one datapath step per cycle
  `SRSW_ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd), "more than one datapath command")
  // idle means the held request has been handed out
  `SRSW_ASSERT(a_idle_empty, s_axis_tready |-> !sts.pend_valid, "request held while idle")
  // a queued request never overwrites a result still waiting at the output
  `SRSW_ASSERT(a_no_overrun, (cmd.scan && sts.slot_due && sts.pend_valid) |-> sts.out_free,
    "output overrun")
  // the final hand-over always has something to deliver
  `SRSW_ASSERT(a_flush_has, cmd.flush |-> (sts.pend_valid && sts.out_free),
    "flush without held request")

endmodule
`default_nettype wire

// ===== design/srsw_ctrl.sv =====
// controller state machine: sequences start, ack and tick handling
`default_nettype none
module srsw_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [srsw_pkg::OP_BITS-1:0]     in_op,
  output logic                             in_ready,
  input  srsw_pkg::srsw_sts_t              sts,
  output srsw_pkg::srsw_cmd_t              cmd
);
  import srsw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_SCAN,
    ST_FIN,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_START) begin
            cmd.start = 1'b1;
          end else if (in_op == OP_ACK) begin
            cmd.ack = 1'b1;
          end else if (in_op == OP_TICK) begin
            cmd.tick   = 1'b1;
            state_next = ST_SLIDE;
          end
        end
      end
      ST_SLIDE: begin
        if (sts.slide_more) begin
          cmd.slide = 1'b1;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_more) begin
          state_next = ST_FIN;
        end else if (!(sts.slot_due && sts.pend_valid && !sts.out_free)) begin
          cmd.scan = 1'b1;
        end
      end
      ST_FIN: begin
        if (!sts.complete_due) begin
          state_next = ST_FLUSH;
        end else if (!(sts.pend_valid && !sts.out_free)) begin
          cmd.complete = 1'b1;
          state_next   = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/srsw_dp.sv =====
// datapath: window slots, counters, pending request and output register
`default_nettype none
module srsw_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [srsw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [srsw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [srsw_pkg::FIELD_BITS-1:0]      frame_count,
  input  logic                                 final_buffer,
  input  logic [srsw_pkg::FIELD_BITS-1:0]      ack_seq,
  input  logic                                 ack_negative,
  input  logic                                 ack_corrupt,
  input  srsw_pkg::srsw_cmd_t                  cmd,
  output srsw_pkg::srsw_sts_t                  sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_kind,
  output logic [srsw_pkg::FIELD_BITS-1:0]      out_seq,
  output logic                                 out_eot,
  output logic                                 out_last
);
  import srsw_pkg::*;

  logic [WS_BITS-1:0]      window_size;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;

  logic [SEQ_BITS-1:0]   window_base;
  logic [FIELD_BITS-1:0] buffer_frames;
  logic                  is_final_buffer;
  logic [TIME_BITS-1:0]  tick_now;

  logic [WINDOW_MAX-1:0] slot_sent;
  logic [WINDOW_MAX-1:0] slot_acked;
  logic [WINDOW_MAX-1:0] slot_force;
  logic [TIME_BITS-1:0]  slot_stamp [WINDOW_MAX];

  logic [CNT_BITS-1:0] scan_idx;
  logic [CNT_BITS-1:0] slide_cnt;

  logic                pend_valid;
  logic                pend_kind;
  logic [SEQ_BITS-1:0] pend_seq;
  logic                pend_eot;

  logic [CNT_BITS-1:0]  ws_eff;
  logic [SEQ_BITS-1:0]  ack_seq_w;
  logic [SEQ_BITS-1:0]  ack_off;
  logic                 ack_hit;
  logic [SLOT_BITS-1:0] ack_slot;
  logic [SLOT_BITS-1:0] idx;
  logic [CMP_BITS-1:0]  seq_ext;
  logic [CMP_BITS-1:0]  frames_ext;
  logic [CMP_BITS-1:0]  base_ext;
  logic [TIME_BITS-1:0] elapsed;
  logic                 timed_out;
  logic                 in_buf;
  logic                 slot_due;
  logic                 seq_eot;
  logic                 queue_new;
  logic                 out_push;

  // window size clamped to 1..WINDOW_MAX
  always_comb begin
    if (32'(window_size) > WINDOW_MAX) begin
      ws_eff = CNT_BITS'(WINDOW_MAX);
    end else if (window_size == '0) begin
      ws_eff = CNT_BITS'(1);
    end else begin
      ws_eff = CNT_BITS'(window_size);
    end
  end

  assign ack_seq_w = SEQ_BITS'(ack_seq);
  assign ack_off   = ack_seq_w - window_base;
  assign ack_hit   = !ack_corrupt && (ack_seq_w >= window_base) &&
                     (32'(ack_off) < 32'(ws_eff));
  assign ack_slot  = SLOT_BITS'(ack_off);

  assign idx        = scan_idx[SLOT_BITS-1:0];
  assign base_ext   = CMP_BITS'(window_base);
  assign seq_ext    = base_ext + CMP_BITS'(scan_idx);
  assign frames_ext = CMP_BITS'(buffer_frames);
  assign in_buf     = seq_ext < frames_ext;
  assign elapsed    = tick_now - slot_stamp[idx];
  assign timed_out  = 32'(elapsed) > 32'(timeout_ticks);
  assign slot_due   = in_buf && (!slot_sent[idx] ||
                      (!slot_acked[idx] && (slot_force[idx] || timed_out)));
  assign seq_eot    = is_final_buffer && ((seq_ext + CMP_BITS'(1)) == frames_ext);

  assign queue_new = (cmd.scan && slot_due) || cmd.complete;
  assign out_push  = (queue_new && pend_valid) || cmd.flush;

  assign sts.slide_more   = slot_acked[0] && (slide_cnt < ws_eff);
  assign sts.scan_more    = scan_idx < ws_eff;
  assign sts.slot_due     = slot_due;
  assign sts.complete_due = base_ext >= frames_ext;
  assign sts.pend_valid   = pend_valid;
  assign sts.out_free     = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_SIZE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WINDOW_SIZE) begin
        window_size <= cfg_data[WS_BITS-1:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
      end
    end
  end

  // buffer state, time and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base     <= '0;
      buffer_frames   <= '0;
      is_final_buffer <= 1'b0;
      tick_now        <= '0;
      scan_idx        <= '0;
      slide_cnt       <= '0;
    end else begin
      if (cmd.start) begin
        buffer_frames   <= frame_count;
        is_final_buffer <= final_buffer;
        window_base     <= '0;
      end
      if (cmd.tick) begin
        tick_now  <= tick_now + TIME_BITS'(1);
        scan_idx  <= '0;
        slide_cnt <= '0;
      end
      if (cmd.slide) begin
        slide_cnt <= slide_cnt + CNT_BITS'(1);
        if (window_base != '1) begin
          window_base <= window_base + SEQ_BITS'(1);
        end
      end
      if (cmd.scan) begin
        scan_idx <= scan_idx + CNT_BITS'(1);
      end
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_sent  <= '0;
      slot_acked <= '0;
      slot_force <= '0;
    end else if (cmd.start) begin
      slot_sent  <= '0;
      slot_acked <= '0;
      slot_force <= '0;
    end else if (cmd.ack && ack_hit) begin
      if (ack_negative) begin
        slot_force[ack_slot] <= 1'b1;
      end else begin
        slot_acked[ack_slot] <= 1'b1;
      end
    end else if (cmd.slide) begin
      slot_sent  <= slot_sent >> 1;
      slot_acked <= slot_acked >> 1;
      slot_force <= slot_force >> 1;
    end else if (cmd.scan && slot_due) begin
      slot_sent[idx]  <= 1'b1;
      slot_force[idx] <= 1'b0;
    end
  end

  // send time stamps, meaningful only while the sent flag is set
  always_ff @(posedge clk) begin
    if (cmd.slide) begin
      for (int i = 0; i < WINDOW_MAX - 1; i++) begin
        slot_stamp[i] <= slot_stamp[i + 1];
      end
    end else if (cmd.scan && slot_due) begin
      slot_stamp[idx] <= tick_now;
    end
  end

  // one request held back so the last of a tick can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (queue_new) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.complete) begin
      pend_kind <= KIND_DONE;
      pend_seq  <= '0;
      pend_eot  <= is_final_buffer;
    end else if (cmd.scan && slot_due) begin
      pend_kind <= KIND_SEND;
      pend_seq  <= SEQ_BITS'(seq_ext);
      pend_eot  <= seq_eot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_kind <= pend_kind;
      out_seq  <= FIELD_BITS'(pend_seq);
      out_eot  <= pend_eot;
      out_last <= cmd.flush;
    end
  end

endmodule
`default_nettype wire
